// File: hw/rtl/sst_pkg.sv
package sst_pkg;

    localparam int SINE_DEPTH_DEF  = 1024;
    localparam int DECAY_DEPTH_DEF = 256;
    localparam int RATE_DEF        = 22050;

    localparam logic [0:0] REQ_START = 1'b0;
    localparam logic [0:0] REQ_TICK  = 1'b1;

    // table build constants, Q30
    localparam longint unsigned HALF_PI_Q30    = 64'd1686629713;
    localparam longint unsigned DECAY_RATE_Q30 = 64'd3435973837;
    localparam longint unsigned ONE_Q30        = 64'd1073741824;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DIV    = 9'b000000010,
        S_LOAD   = 9'b000000100,
        S_PHASE  = 9'b000001000,
        S_ROM    = 9'b000010000,
        S_MUL    = 9'b000100000,
        S_UPDATE = 9'b001000000,
        S_OUT    = 9'b010000000,
        S_ZERO   = 9'b100000000
    } state_t;

    typedef struct packed {
        logic div_go;
        logic load;
        logic phase;
        logic rom;
        logic mul_go;
        logic update;
        logic out_tone;
        logic out_zero;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic mul_done;
        logic active;
    } stat_t;

endpackage

// File: hw/rtl/sst_ctrl.sv
module sst_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_type,
    output logic           in_ready,
    input  logic           out_busy,
    input  sst_pkg::stat_t stat,
    output sst_pkg::cmd_t  cmd
);
    import sst_pkg::*;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_type == REQ_START)
                    begin
                        cmd.div_go = 1'b1;
                        state_next = S_DIV;
                    end
                    else if (stat.active)
                        state_next = S_PHASE;
                    else
                        state_next = S_ZERO;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load = 1'b1;
                state_next = S_IDLE;
            end
            S_PHASE:
            begin
                cmd.phase = 1'b1;
                state_next = S_ROM;
            end
            S_ROM:
            begin
                cmd.rom = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_go = !stat.mul_done;
                if (stat.mul_done)
                    state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_busy)
                begin
                    cmd.out_tone = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ZERO:
            begin
                if (!out_busy)
                begin
                    cmd.out_zero = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: hw/rtl/sst_datapath.sv
module sst_datapath
#(
    parameter int SINE_TABLE_DEPTH  = sst_pkg::SINE_DEPTH_DEF,
    parameter int DECAY_TABLE_DEPTH = sst_pkg::DECAY_DEPTH_DEF,
    parameter int SAMPLE_RATE       = sst_pkg::RATE_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  sst_pkg::cmd_t  cmd,
    output sst_pkg::stat_t stat,
    input  logic [13:0]    start_freq,
    input  logic [13:0]    end_freq,
    input  logic [15:0]    tone_samples,
    input  logic [15:0]    attack_samples,
    input  logic [14:0]    tone_gain,
    output logic [15:0]    sample_reg,
    output logic           last_reg,
    output logic           playing_reg
);
    import sst_pkg::*;

    localparam int SW = $clog2(SINE_TABLE_DEPTH);
    localparam int DW = $clog2(DECAY_TABLE_DEPTH);
    localparam logic [16:0] FULL = 17'd65536;

    // floor(f * 2^32 / rate) = (f * INC_M) >> 31, exact for 14-bit f
    localparam longint unsigned INC_M = ((64'd1 << 63) + 64'(SAMPLE_RATE) - 64'd1)
                                        / 64'(SAMPLE_RATE);
    localparam logic [25:0] INC_ML = INC_M[25:0];
    localparam logic [25:0] INC_MH = INC_M[51:26];

    logic [15:0] sine_rom [SINE_TABLE_DEPTH];
    logic [15:0] decay_rom [DECAY_TABLE_DEPTH];

    // quarter-wave sine, 8-term series in Q30
    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++)
    begin : g_sine
        localparam longint unsigned X  = (HALF_PI_Q30 * 64'(2 * k + 1))
                                         / 64'(2 * SINE_TABLE_DEPTH);
        localparam longint unsigned X2 = (X * X) >> 30;
        localparam longint unsigned T1 = ((X * X2) >> 30) / 6;
        localparam longint unsigned T2 = ((T1 * X2) >> 30) / 20;
        localparam longint unsigned T3 = ((T2 * X2) >> 30) / 42;
        localparam longint unsigned T4 = ((T3 * X2) >> 30) / 72;
        localparam longint unsigned T5 = ((T4 * X2) >> 30) / 110;
        localparam longint unsigned T6 = ((T5 * X2) >> 30) / 156;
        localparam longint unsigned T7 = ((T6 * X2) >> 30) / 210;
        localparam longint S = longint'(X) - longint'(T1) + longint'(T2) - longint'(T3)
                               + longint'(T4) - longint'(T5) + longint'(T6) - longint'(T7);
        localparam longint unsigned Q = (S > 0) ? ((64'(S) + 64'd16384) >> 15) : 64'd0;
        assign sine_rom[k] = (Q > 64'd32767) ? 16'd32767 : Q[15:0];
    end

    // exp(-y) as a series of exp(-y/8), squared three times
    for (genvar k = 0; k < DECAY_TABLE_DEPTH; k++)
    begin : g_decay
        localparam longint unsigned Y  = (DECAY_RATE_Q30 * 64'(k)) / 64'(DECAY_TABLE_DEPTH);
        localparam longint unsigned Z  = Y >> 3;
        localparam longint unsigned E1 = (ONE_Q30 * Z) >> 30;
        localparam longint unsigned E2 = ((E1 * Z) >> 30) / 2;
        localparam longint unsigned E3 = ((E2 * Z) >> 30) / 3;
        localparam longint unsigned E4 = ((E3 * Z) >> 30) / 4;
        localparam longint unsigned E5 = ((E4 * Z) >> 30) / 5;
        localparam longint unsigned E6 = ((E5 * Z) >> 30) / 6;
        localparam longint unsigned E7 = ((E6 * Z) >> 30) / 7;
        localparam longint unsigned E8 = ((E7 * Z) >> 30) / 8;
        localparam longint SE = longint'(ONE_Q30) - longint'(E1) + longint'(E2) - longint'(E3)
                                + longint'(E4) - longint'(E5) + longint'(E6) - longint'(E7)
                                + longint'(E8);
        localparam longint unsigned V0 = (SE <= 0) ? 64'd0
                                       : ((SE > longint'(ONE_Q30)) ? ONE_Q30 : 64'(SE));
        localparam longint unsigned V1 = (V0 * V0) >> 30;
        localparam longint unsigned V2 = (V1 * V1) >> 30;
        localparam longint unsigned V3 = (V2 * V2) >> 30;
        localparam longint unsigned QD = (V3 + 64'd16384) >> 15;
        assign decay_rom[k] = (QD > 64'd32768) ? 16'd32768 : QD[15:0];
    end

    logic [31:0] phase_acc_reg, freq_acc_reg, freq_step_reg;
    logic [16:0] time_acc_reg, time_step_reg, ramp_acc_reg, ramp_step_reg;
    logic [15:0] samples_left_reg;
    logic [14:0] gain_reg;

    // phase increments by reciprocal multiply, alongside two restoring dividers,
    // one quotient bit per cycle: 65536/n and 65536/att
    logic [13:0] f0_reg, f1_reg;
    logic [39:0] lo_reg;
    logic [31:0] inc0_reg, inc1_reg;
    logic [16:0] num2_reg, num3_reg;
    logic [16:0] rem2_reg, rem3_reg;
    logic [15:0] len_reg, att_reg;
    logic [5:0]  dcnt_reg;
    logic        dbusy_reg;
    // signed diff / n, 33-bit magnitude
    logic [32:0] dnum_reg;
    logic [16:0] drem_reg;
    logic        dneg_reg;
    logic        phase2_reg;

    logic [13:0] mf;
    logic [25:0] mm;
    logic [39:0] mp;
    logic [62:0] inc_sum;
    assign mf = (dcnt_reg > 6'd15) ? f0_reg : f1_reg;
    assign mm = dcnt_reg[0] ? INC_ML : INC_MH;
    assign mp = 40'(mf) * 40'(mm);
    assign inc_sum = {mp[36:0], 26'd0} + {23'd0, lo_reg};

    logic [17:0] t2, t3;
    logic [17:0] td;
    assign t2 = {rem2_reg, num2_reg[16]};
    assign t3 = {rem3_reg, num3_reg[16]};
    assign td = {drem_reg, dnum_reg[32]};

    logic [32:0] diff;
    assign diff = {1'b0, inc1_reg} - {1'b0, inc0_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg  <= 1'b0;
            dcnt_reg   <= '0;
            phase2_reg <= 1'b0;
        end
        else if (cmd.div_go)
        begin
            dbusy_reg  <= 1'b1;
            phase2_reg <= 1'b0;
            dcnt_reg   <= 6'd17;
        end
        else if (dbusy_reg)
        begin
            if (dcnt_reg != 0)
                dcnt_reg <= dcnt_reg - 6'd1;
            else if (!phase2_reg)
            begin
                phase2_reg <= 1'b1;
                dcnt_reg   <= 6'd33;
            end
            else
                dbusy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_go)
        begin
            f0_reg   <= start_freq;
            f1_reg   <= end_freq;
            num2_reg <= FULL;
            num3_reg <= FULL;
            rem2_reg <= '0;
            rem3_reg <= '0;
            len_reg  <= tone_samples;
            att_reg  <= attack_samples;
            gain_reg <= tone_gain;
        end
        else if (dbusy_reg && !phase2_reg && dcnt_reg != 0)
        begin
            // low partial product first, then add the high one
            if (dcnt_reg[0] && dcnt_reg >= 6'd15)
                lo_reg <= mp;
            if (dcnt_reg == 6'd16)
                inc0_reg <= inc_sum[62:31];
            if (dcnt_reg == 6'd14)
                inc1_reg <= inc_sum[62:31];
            if (t2 >= {2'b0, len_reg})
            begin
                rem2_reg <= 17'(t2 - {2'b0, len_reg});
                num2_reg <= {num2_reg[15:0], 1'b1};
            end
            else
            begin
                rem2_reg <= t2[16:0];
                num2_reg <= {num2_reg[15:0], 1'b0};
            end
            if (t3 >= {2'b0, att_reg})
            begin
                rem3_reg <= 17'(t3 - {2'b0, att_reg});
                num3_reg <= {num3_reg[15:0], 1'b1};
            end
            else
            begin
                rem3_reg <= t3[16:0];
                num3_reg <= {num3_reg[15:0], 1'b0};
            end
        end
        else if (dbusy_reg && !phase2_reg)
        begin
            dneg_reg <= diff[32];
            dnum_reg <= diff[32] ? (33'd0 - diff) : diff;
            drem_reg <= '0;
        end
        else if (dbusy_reg && dcnt_reg != 0)
        begin
            if (td >= {2'b0, len_reg})
            begin
                drem_reg <= 17'(td - {2'b0, len_reg});
                dnum_reg <= {dnum_reg[31:0], 1'b1};
            end
            else
            begin
                drem_reg <= td[16:0];
                dnum_reg <= {dnum_reg[31:0], 1'b0};
            end
        end
    end

    assign stat.div_done = dbusy_reg && phase2_reg && dcnt_reg == 0;

    // tick pipeline
    logic [31:0] ph;
    logic [SW-1:0] sidx_reg;
    logic [DW-1:0] didx_reg;
    logic          neg_reg;
    logic [15:0]   dec_reg;
    logic [31:0]   m_reg;
    logic [2:0]    mstep_reg;
    logic [47:0]   sidx_prod;
    logic [17:0]   sidx_full;
    logic [SW-1:0] sidx_raw;
    logic [31:0]   didx_prod;
    logic [15:0]   didx_full;
    logic [17:0]   ramp_sum;

    assign ph = phase_acc_reg + freq_acc_reg;
    assign sidx_prod = 48'(ph[29:0]) * 48'(SINE_TABLE_DEPTH);
    assign sidx_full = sidx_prod[47:30];
    assign sidx_raw  = (sidx_full > 18'(SINE_TABLE_DEPTH - 1)) ? SW'(SINE_TABLE_DEPTH - 1)
                                                               : sidx_full[SW-1:0];
    assign didx_prod = 32'(time_acc_reg) * 32'(DECAY_TABLE_DEPTH);
    assign didx_full = didx_prod[31:16];
    assign ramp_sum = {1'b0, ramp_acc_reg} + {1'b0, ramp_step_reg};

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    always_comb
    begin
        mul_a = m_reg;
        case (mstep_reg)
            3'd0: mul_b = {15'd0, ramp_acc_reg};
            3'd1: mul_b = {16'd0, dec_reg};
            3'd2: mul_b = {17'd0, gain_reg};
            default: mul_b = 32'd32000;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg    <= '0;
            freq_acc_reg     <= '0;
            freq_step_reg    <= '0;
            time_acc_reg     <= '0;
            time_step_reg    <= '0;
            ramp_acc_reg     <= '0;
            ramp_step_reg    <= '0;
            samples_left_reg <= '0;
            mstep_reg        <= '0;
            playing_reg      <= 1'b0;
            last_reg         <= 1'b0;
            sample_reg       <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                samples_left_reg <= len_reg;
                phase_acc_reg    <= '0;
                freq_acc_reg     <= inc0_reg;
                time_acc_reg     <= '0;
                freq_step_reg    <= '0;
                time_step_reg    <= '0;
                ramp_acc_reg     <= FULL;
                ramp_step_reg    <= '0;
                if (len_reg != 0)
                begin
                    freq_step_reg <= dneg_reg ? (32'd0 - dnum_reg[31:0]) : dnum_reg[31:0];
                    time_step_reg <= num2_reg;
                    if (att_reg != 0)
                    begin
                        ramp_acc_reg  <= '0;
                        ramp_step_reg <= num3_reg;
                    end
                end
            end
            if (cmd.phase)
                phase_acc_reg <= ph;
            if (cmd.rom)
                mstep_reg <= '0;
            if (cmd.mul_go)
                mstep_reg <= mstep_reg + 3'd1;
            if (cmd.update)
            begin
                freq_acc_reg     <= freq_acc_reg + freq_step_reg;
                time_acc_reg     <= time_acc_reg + time_step_reg;
                ramp_acc_reg     <= (ramp_sum > {1'b0, FULL}) ? FULL : ramp_sum[16:0];
                samples_left_reg <= samples_left_reg - 16'd1;
            end
            if (cmd.out_tone)
            begin
                playing_reg <= 1'b1;
                // count already advanced: zero left means this was the final sample
                last_reg    <= samples_left_reg == 16'd0;
                sample_reg  <= neg_reg ? (16'd0 - m_reg[15:0]) : m_reg[15:0];
            end
            if (cmd.out_zero)
            begin
                playing_reg <= 1'b0;
                last_reg    <= 1'b0;
                sample_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.phase)
        begin
            neg_reg  <= ph[31];
            sidx_reg <= ph[30] ? (SW'(SINE_TABLE_DEPTH - 1) - sidx_raw) : sidx_raw;
            didx_reg <= (didx_full > 16'(DECAY_TABLE_DEPTH - 1)) ? DW'(DECAY_TABLE_DEPTH - 1)
                                                                : didx_full[DW-1:0];
        end
        if (cmd.rom)
        begin
            dec_reg <= decay_rom[didx_reg];
            m_reg   <= {16'd0, sine_rom[sidx_reg]};
        end
        if (cmd.mul_go)
        begin
            case (mstep_reg)
                3'd0: m_reg <= 32'(mul_p >> 16);
                3'd1: m_reg <= 32'(mul_p >> 15);
                3'd2: m_reg <= (32'(mul_p >> 15) > 32'd32768) ? 32'd32768 : 32'(mul_p >> 15);
                default: m_reg <= 32'(mul_p >> 15);
            endcase
        end
    end

    assign stat.mul_done = mstep_reg == 3'd4;
    assign stat.active   = samples_left_reg != 0;

endmodule

// File: hw/rtl/sine_sweep_tone_synth_unit.sv
// Sine chirp generator. Slave channel s_axis: a request is either a start
// (tuser = 0) that loads frequencies, length, attack and gain, or a tick
// (tuser = 1) that asks for one sample. A start gives no result; every tick
// gives one result on m_axis: tdata is the signed PCM16 sample, tuser flags
// a sample of an active tone, tlast the final sample of the tone.
// A start runs through these steps before the next request is taken: the
// accept, the two restoring dividers for the time and attack steps (the
// phase increments come from a reciprocal multiply in the same window),
// the signed glide step and the load.
// A tick of an active tone runs phase update, table read, the multiplier
// steps (ramp, decay, gain, output scale), state update and the output
// register before its result is valid. An idle tick's zero result is
// registered from the zero state, and then the block is idle again.
// One request is handled at a time; s_axis_tready is high only when idle.
// The output register holds a result until taken; a stalled receiver holds
// the next result in the controller. After reset the block is idle and
// ticks give zero samples with tuser low.
module sine_sweep_tone_synth_unit
#(
    parameter int SINE_TABLE_DEPTH  = sst_pkg::SINE_DEPTH_DEF,
    parameter int DECAY_TABLE_DEPTH = sst_pkg::DECAY_DEPTH_DEF,
    parameter int SAMPLE_RATE       = sst_pkg::RATE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // start_freq[13:0], end_freq[27:14], tone_samples[43:28],
    // attack_samples[59:44], tone_gain[74:60], zero fill
    input  logic [79:0] s_axis_tdata,
    // req_type
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // sample
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast,
    // playing
    output logic        m_axis_tuser
);
    import sst_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  valid_reg;
    logic  out_busy;

    assign out_busy = valid_reg && !m_axis_tready;

    sst_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_type  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .out_busy (out_busy),
        .stat     (stat),
        .cmd      (cmd)
    );

    sst_datapath
    #(
        .SINE_TABLE_DEPTH  (SINE_TABLE_DEPTH),
        .DECAY_TABLE_DEPTH (DECAY_TABLE_DEPTH),
        .SAMPLE_RATE       (SAMPLE_RATE)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .start_freq     (s_axis_tdata[13:0]),
        .end_freq       (s_axis_tdata[27:14]),
        .tone_samples   (s_axis_tdata[43:28]),
        .attack_samples (s_axis_tdata[59:44]),
        .tone_gain      (s_axis_tdata[74:60]),
        .sample_reg     (m_axis_tdata),
        .last_reg       (m_axis_tlast),
        .playing_reg    (m_axis_tuser)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (cmd.out_tone || cmd.out_zero)
            valid_reg <= 1'b1;
        else if (m_axis_tready)
            valid_reg <= 1'b0;
    end

    assign m_axis_tvalid = valid_reg;

    a_one_out: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.out_tone && cmd.out_zero))
        else $error("tone and zero result issued together");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_tone || cmd.out_zero) |-> !(m_axis_tvalid && !m_axis_tready))
        else $error("result overwritten while stalled");

    a_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 16'd0 && !m_axis_tlast))
        else $error("idle result not zero");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

class tone_scoreboard;
    logic [15:0] sine_rom [1024];
    logic [15:0] decay_rom [256];
    logic [31:0] phase_acc, freq_acc, freq_step;
    logic [16:0] time_acc, time_step;
    logic [31:0] ramp_acc, ramp_step;
    logic [15:0] samples_left;
    logic [14:0] gain;
    logic [17:0] sample_q[$];
    int errors;

    function new();
        longint unsigned x, x2, term, q, y, z, v;
        longint sum;
        for (int k = 0; k < 1024; k++)
        begin
            x = (64'd1686629713 * (2 * k + 1)) / 2048;
            x2 = (x * x) >> 30;
            term = x;
            sum = longint'(x);
            for (int n = 1; n <= 7; n++)
            begin
                term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
                if (n % 2 == 1) sum = sum - longint'(term);
                else sum = sum + longint'(term);
            end
            q = (sum > 0) ? ((sum + 16384) >> 15) : 0;
            sine_rom[k] = (q > 32767) ? 16'd32767 : q[15:0];
        end
        for (int k = 0; k < 256; k++)
        begin
            y = (64'd3435973837 * k) / 256;
            z = y / 8;
            term = 64'd1073741824;
            sum = 64'sd1073741824;
            for (int n = 1; n <= 8; n++)
            begin
                term = ((term * z) >> 30) / n;
                if (n % 2 == 1) sum = sum - longint'(term);
                else sum = sum + longint'(term);
            end
            v = (sum > 0) ? sum : 0;
            if (v > 64'd1073741824) v = 64'd1073741824;
            for (int j = 0; j < 3; j++) v = (v * v) >> 30;
            q = (v + 16384) >> 15;
            decay_rom[k] = (q > 32768) ? 16'd32768 : q[15:0];
        end
        phase_acc = 0; freq_acc = 0; freq_step = 0; time_acc = 0; time_step = 0;
        ramp_acc = 0; ramp_step = 0; samples_left = 0; gain = 0; errors = 0;
    endfunction

    function logic [31:0] phase_inc(logic [13:0] f);
        longint unsigned t;
        t = (longint'(f) << 32) / 22050;
        return t[31:0];
    endfunction

    function void note_request(logic kind, logic [79:0] d);
        logic [31:0] i0, i1;
        longint diff, quo;
        logic [15:0] n, att;
        logic [31:0] ph, pos;
        int sidx, didx;
        longint unsigned m;
        logic [15:0] s;
        if (kind == sst_pkg::REQ_START)
        begin
            n = d[43:28];
            att = d[59:44];
            i0 = phase_inc(d[13:0]);
            i1 = phase_inc(d[27:14]);
            samples_left = n;
            phase_acc = 0; freq_acc = i0; freq_step = 0; time_acc = 0; time_step = 0;
            ramp_acc = 65536; ramp_step = 0; gain = d[74:60];
            if (n != 0)
            begin
                diff = longint'(i1) - longint'(i0);
                quo = diff / longint'(n);
                freq_step = quo[31:0];
                time_step = 65536 / n;
                if (att != 0)
                begin
                    ramp_acc = 0;
                    ramp_step = 65536 / att;
                end
            end
            return;
        end
        if (samples_left == 0)
        begin
            sample_q.push_back(18'd0);
            return;
        end
        phase_acc = phase_acc + freq_acc;
        ph = phase_acc;
        pos = {2'b00, ph[29:0]};
        sidx = (longint'(pos) * 1024) >> 30;
        if (ph[30]) sidx = 1023 - sidx;
        didx = (longint'(time_acc) * 256) >> 16;
        if (didx > 255) didx = 255;
        m = (longint'(sine_rom[sidx]) * (ramp_acc > 65536 ? 65536 : ramp_acc)) >> 16;
        m = (m * decay_rom[didx]) >> 15;
        m = (m * gain) >> 15;
        if (m > 32768) m = 32768;
        m = (m * 32000) >> 15;
        s = ph[31] ? 16'(-m) : m[15:0];
        sample_q.push_back({1'b1, samples_left == 1, s});
        freq_acc = freq_acc + freq_step;
        time_acc = time_acc + time_step;
        ramp_acc = (ramp_acc + ramp_step > 65536) ? 65536 : ramp_acc + ramp_step;
        samples_left = samples_left - 1;
    endfunction

    function void check_sample(logic [15:0] s, logic lst, logic ply);
        logic [17:0] e;
        if (sample_q.size() == 0)
        begin
            $display("%0t: unexpected sample expected none actual %h", $time, s);
            errors++;
            return;
        end
        e = sample_q.pop_front();
        if (e[15:0] !== s || e[16] !== lst || e[17] !== ply)
        begin
            $display("%0t: sample mismatch expected %h/%b/%b actual %h/%b/%b",
                     $time, e[15:0], e[16], e[17], s, lst, ply);
            errors++;
        end
    endfunction
endclass

module tb_top;
    logic clk = 0;
    logic rst_n = 0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [79:0] s_axis_tdata = 0;
    logic s_axis_tuser = 0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [15:0] m_axis_tdata;
    logic m_axis_tlast;
    logic m_axis_tuser;

    tone_scoreboard synth_model = new();
    int idle_cycles = 0;
    bit hold_off = 0;
    bit stim_done = 0;

    always #1 clk = ~clk;

    sine_sweep_tone_synth_unit dut (.*);

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            synth_model.note_request(s_axis_tuser, s_axis_tdata);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            synth_model.check_sample(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end

    // watchdog on cycles without any accepted request or sample
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (hold_off)
            m_axis_tready <= 0;
        else
            case ($urandom_range(0, 3))
                0: m_axis_tready <= ($urandom_range(0, 1) == 0);
                default: m_axis_tready <= 1;
            endcase
    end

    task automatic send_request(input logic kind, input logic [79:0] d);
        s_axis_tvalid <= 1;
        s_axis_tuser <= kind;
        s_axis_tdata <= d;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic gap();
        s_axis_tvalid <= 0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
    endtask

    function automatic logic [79:0] pack_start(logic [13:0] f0, logic [13:0] f1,
                                               logic [15:0] n, logic [15:0] att,
                                               logic [14:0] g);
        return {5'b0, g, att, n, f1, f0};
    endfunction

    task automatic send_tone(input logic [79:0] d, input int ticks);
        int burst;
        send_request(sst_pkg::REQ_START, d);
        burst = $urandom_range(1, 20);
        for (int i = 0; i < ticks; i++)
        begin
            send_request(sst_pkg::REQ_TICK, $urandom());
            if (--burst == 0)
            begin
                gap();
                burst = $urandom_range(1, 20);
            end
        end
    endtask

    function automatic logic [13:0] rand_freq();
        return ($urandom_range(0, 9) == 0) ? 14'($urandom()) : 14'($urandom_range(0, 11025));
    endfunction

    initial
    begin
        int ticks_sent;
        int n;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // idle ticks after reset
        send_tone(pack_start(0, 0, 0, 0, 0), 2);
        // extremes of the fields
        send_tone(pack_start(14'h3FFF, 0, 4, 0, 15'h7FFF), 5);
        send_tone(pack_start(11025, 11025, 3, 16'hFFFF, 15'h7FFF), 3);
        send_tone(pack_start(1000, 5000, 8, 3, 15'h7FFF), 4);
        // restart while playing
        send_tone(pack_start(440, 880, 1, 1, 16384), 2);
        send_tone(pack_start(200, 100, 16'hFFFF, 0, 0), 2);
        // zero length stops the running tone
        send_tone(pack_start(300, 300, 0, 5, 100), 2);
        // hold off the receiver while requests keep coming
        hold_off = 1;
        fork
            send_tone(pack_start(1234, 4321, 20, 2, 30000), 20);
            begin
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
        join
        ticks_sent = 0;
        while (ticks_sent < 950)
        begin
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535)
                                             : $urandom_range(0, 60);
            send_tone(pack_start(rand_freq(), rand_freq(), n,
                                 ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                             : 16'($urandom_range(0, 40)),
                                 15'($urandom())),
                      $urandom_range(0, 70));
            ticks_sent += 35;
        end
        s_axis_tvalid <= 0;
        stim_done = 1;
    end

    initial
    begin
        int drain;
        wait (stim_done);
        drain = 0;
        while (synth_model.sample_q.size() != 0 && drain < 100000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (100) @(posedge clk);
        if (synth_model.errors == 0 && synth_model.sample_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
